@@ hdl/pscc_pkg.sv @@
// Shared constants for the path-set conflict checker.
`default_nettype none
package pscc_pkg;
  localparam int MAX_AGENTS = 16;
  localparam int MAX_STEPS  = 256;
  localparam int COORD_BITS = 8;
  localparam int AGENT_BITS = $clog2(MAX_AGENTS);
  localparam int STEP_BITS  = $clog2(MAX_STEPS);
  localparam int LEN_BITS   = STEP_BITS + 1;
  localparam int CNT_BITS   = AGENT_BITS + 1;
  localparam int ADDR_BITS  = AGENT_BITS + STEP_BITS;
  localparam int POS_BITS   = 2 * COORD_BITS;
  localparam int COUNT_BITS = 7;
  localparam int COST_BITS  = 13;
  localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
endpackage
`default_nettype wire

@@ hdl/path_set_conflict_checker.sv @@
// Path-set conflict checker: path store, pair walker and result register.
//
// Load transfers (tuser = 0) write one path position each. A run transfer
// (tuser = 1) first sums path lengths, one agent per cycle, and then walks
// every agent pair i<j through the single read port of the position memory:
// S_PAIR, S_A0, S_B0 and S_W0 open a pair and fetch its step-0 positions,
// S_CHK checks each step, S_NA, S_NB, S_NC and S_EDGE fetch the next positions
// and test a swap ahead of each further step, and S_NEXT closes the pair.
// A pair stops at its first conflict. The result waits in an output register;
// loads are taken while it waits.
`default_nettype none
module path_set_conflict_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // agent[3:0] step[11:4] pos_row[19:12] pos_col[27:20]
  input  wire logic        s_tuser,  // cmd
  input  wire logic        s_tlast,  // last_step
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,  // first_agent[3:0] second_agent[7:4] conflict_step[15:8]
                                     // where_row[23:16] where_col[31:24] other_row[39:32]
                                     // other_col[47:40] conflict_count[54:48]
                                     // makespan[63:55] total_cost[76:64]
  output logic [1:0]       m_tuser   // found[0] kind[1]
);
  localparam int AB = pscc_pkg::AGENT_BITS;
  localparam int SB = pscc_pkg::STEP_BITS;
  localparam int LB = pscc_pkg::LEN_BITS;
  localparam int NB = pscc_pkg::CNT_BITS;
  localparam int PB = pscc_pkg::POS_BITS;
  localparam int CB = pscc_pkg::COORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_PAIR = 4'd2, S_A0 = 4'd3,
                         S_B0 = 4'd4, S_W0 = 4'd5, S_CHK = 4'd6, S_NA = 4'd7,
                         S_NB = 4'd8, S_NC = 4'd9, S_EDGE = 4'd10, S_NEXT = 4'd11,
                         S_DONE = 4'd12;

  logic [3:0] state;
  logic [4:0] agents_in_use;
  logic [LB-1:0] path_len [pscc_pkg::MAX_AGENTS];
  logic [PB-1:0] mem [1 << pscc_pkg::ADDR_BITS];
  logic [PB-1:0] rdata;
  logic [pscc_pkg::ADDR_BITS-1:0] raddr;

  logic [AB-1:0] i, j;
  logic [NB-1:0] k;
  logic [LB-1:0] la, lb, lmax;
  logic [SB-1:0] t;
  logic [PB-1:0] pa, pb, na, nb;
  logic hit, hit_kind;
  logic [SB-1:0] hit_step;
  logic [PB-1:0] hit_where, hit_other;

  logic found, fkind;
  logic [AB-1:0] fa, fb;
  logic [SB-1:0] fstep;
  logic [PB-1:0] fwhere, fother;
  logic [pscc_pkg::COUNT_BITS-1:0] count;
  logic [LB-1:0] mk;
  logic [pscc_pkg::COST_BITS-1:0] cost;

  logic [NB-1:0] n_eff;
  logic load_xfer, run_xfer;
  logic [LB-1:0] t1, len_k;

  function automatic logic [LB-1:0] eff(input logic [LB-1:0] l);
    return (l == '0) ? LB'(1) : l;
  endfunction

  function automatic logic [SB-1:0] clampt(input logic [LB-1:0] tt, input logic [LB-1:0] l);
    return (tt >= l) ? SB'(l - LB'(1)) : tt[SB-1:0];
  endfunction

  // effective agent count
  always_comb begin
    if (agents_in_use == '0) n_eff = NB'(1);
    else if (NB'(agents_in_use) > NB'(pscc_pkg::MAX_AGENTS)) n_eff = NB'(pscc_pkg::MAX_AGENTS);
    else n_eff = NB'(agents_in_use);
  end

  assign s_tready  = (state == S_IDLE) && (!s_tuser || !m_tvalid || m_tready);
  assign load_xfer = s_tvalid && s_tready && !s_tuser;
  assign run_xfer  = s_tvalid && s_tready && s_tuser;
  assign t1        = LB'(t) + LB'(1);
  assign len_k     = eff(path_len[k[AB-1:0]]);

  // read address per sequencer state
  always_comb begin
    case (state)
      S_A0:    raddr = {i, clampt(LB'(t), la)};
      S_B0:    raddr = {j, clampt(LB'(t), lb)};
      S_NA:    raddr = {i, clampt(t1, la)};
      S_NB:    raddr = {j, clampt(t1, lb)};
      default: raddr = '0;
    endcase
  end

  // position memory, row in the upper half
  always_ff @(posedge clk) begin
    if (load_xfer) mem[{s_tdata[AB-1:0], s_tdata[AB+SB-1:AB]}] <= {s_tdata[19:12], s_tdata[27:20]};
    rdata <= mem[raddr];
  end

  // config register and path lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      agents_in_use <= 5'd2;
      for (int a = 0; a < pscc_pkg::MAX_AGENTS; a++) path_len[a] <= '0;
    end else begin
      if (cfg_we) agents_in_use <= cfg_wdata;
      if (load_xfer && s_tlast)
        path_len[s_tdata[AB-1:0]] <= LB'(s_tdata[AB+SB-1:AB]) + LB'(1);
    end
  end

  // run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (run_xfer) begin
          state <= S_SUM;
          k <= '0; found <= 1'b0; fkind <= 1'b0; fa <= '0; fb <= '0;
          fstep <= '0; fwhere <= '0; fother <= '0;
          count <= '0; mk <= '0; cost <= '0;
        end
        S_SUM: begin
          if (len_k > mk) mk <= len_k;
          cost <= cost + pscc_pkg::COST_BITS'(len_k);
          if (k + NB'(1) >= n_eff) begin
            i <= '0; j <= AB'(1);
            state <= (n_eff > NB'(1)) ? S_PAIR : S_DONE;
          end
          k <= k + NB'(1);
        end
        S_PAIR: begin
          la <= eff(path_len[i]);
          lb <= eff(path_len[j]);
          lmax <= (eff(path_len[i]) > eff(path_len[j])) ? eff(path_len[i]) : eff(path_len[j]);
          t <= '0; hit <= 1'b0;
          state <= S_A0;
        end
        S_A0: state <= S_B0;
        S_B0: begin pa <= rdata; state <= S_W0; end
        S_W0: begin pb <= rdata; state <= S_CHK; end
        S_CHK: begin
          if (pa == pb) begin
            hit <= 1'b1; hit_kind <= 1'b0; hit_step <= t;
            hit_where <= pa; hit_other <= pb;
            state <= S_NEXT;
          end else if (t1 < lmax) state <= S_NA;
          else state <= S_NEXT;
        end
        S_NA: state <= S_NB;
        S_NB: begin na <= rdata; state <= S_NC; end
        S_NC: begin nb <= rdata; state <= S_EDGE; end
        S_EDGE: begin
          if (pa == nb && pb == na) begin
            hit <= 1'b1; hit_kind <= 1'b1; hit_step <= t1[SB-1:0];
            hit_where <= pa; hit_other <= na;
            state <= S_NEXT;
          end else begin
            pa <= na; pb <= nb; t <= t1[SB-1:0];
            state <= S_CHK;
          end
        end
        S_NEXT: begin
          if (hit) begin
            if (count != pscc_pkg::COUNT_BITS'(pscc_pkg::COUNT_MAX)) count <= count + 1'b1;
            if (!found) begin
              found <= 1'b1; fa <= i; fb <= j; fstep <= hit_step; fkind <= hit_kind;
              fwhere <= hit_where; fother <= hit_other;
            end
          end
          if (NB'(j) + NB'(1) < n_eff) begin
            j <= j + AB'(1); state <= S_PAIR;
          end else if (NB'(i) + NB'(2) < n_eff) begin
            i <= i + AB'(1); j <= i + AB'(2); state <= S_PAIR;
          end else state <= S_DONE;
        end
        S_DONE: begin
          m_tvalid <= 1'b1;
          m_tuser  <= {fkind, found};
          m_tdata  <= {3'b0, cost, mk, count, fother[CB-1:0], fother[PB-1:CB],
                       fwhere[CB-1:0], fwhere[PB-1:CB], fstep, fb, fa};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/path_set_conflict_monitor.sv @@
// Monitor for the path-set conflict checker: tracks loads, predicts run reports, compares.
`timescale 1ns / 100ps
`default_nettype none
module path_set_conflict_monitor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [79:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic                            found;
    logic [pscc_pkg::AGENT_BITS-1:0] lo_agent;
    logic [pscc_pkg::AGENT_BITS-1:0] hi_agent;
    logic [7:0]                      conflict_step;
    logic                            kind;
    logic [7:0]                      where_row;
    logic [7:0]                      where_col;
    logic [7:0]                      other_row;
    logic [7:0]                      other_col;
    logic [6:0]                      conflict_count;
    logic [8:0]                      makespan;
    logic [12:0]                     total_cost;
  } report_t;

  logic [pscc_pkg::POS_BITS-1:0] grid_pos [pscc_pkg::MAX_AGENTS][pscc_pkg::MAX_STEPS];
  logic [pscc_pkg::LEN_BITS-1:0] plen [pscc_pkg::MAX_AGENTS];
  logic [4:0]                    n_active;
  report_t                       reports_due [$];

  function automatic int eff_length(int a);
    return plen[a] == 0 ? 1 : int'(plen[a]);
  endfunction

  function automatic logic [pscc_pkg::POS_BITS-1:0] pos_of(int a, int t);
    int n;
    n = eff_length(a);
    if (t >= n) t = n - 1;
    return grid_pos[a][t];
  endfunction

  // walk all pairs in order, first conflict wins
  function automatic report_t predict_report();
    report_t r;
    int n, span, la, lb, len;
    logic [pscc_pkg::POS_BITS-1:0] pa, pb, na, nb;
    logic hit;
    r = '0;
    n = (n_active == 0) ? 1 :
        (n_active > pscc_pkg::MAX_AGENTS ? pscc_pkg::MAX_AGENTS : int'(n_active));
    span = 0;
    for (int i = 0; i < n; i++) begin
      la = eff_length(i);
      if (la > span) span = la;
      r.total_cost += pscc_pkg::COST_BITS'(la);
      for (int j = i + 1; j < n; j++) begin
        lb = eff_length(j);
        len = la > lb ? la : lb;
        hit = 1'b0;
        for (int t = 0; t < len && !hit; t++) begin
          pa = pos_of(i, t);
          pb = pos_of(j, t);
          if (pa == pb) begin
            hit = 1'b1;
            if (!r.found) begin
              r.found = 1'b1;
              r.lo_agent = pscc_pkg::AGENT_BITS'(i);
              r.hi_agent = pscc_pkg::AGENT_BITS'(j);
              r.conflict_step = 8'(t); r.kind = 1'b0;
              {r.where_row, r.where_col} = pa; {r.other_row, r.other_col} = pb;
            end
          end else if (t + 1 < len) begin
            na = pos_of(i, t + 1);
            nb = pos_of(j, t + 1);
            if (pa == nb && pb == na) begin
              hit = 1'b1;
              if (!r.found) begin
                r.found = 1'b1;
                r.lo_agent = pscc_pkg::AGENT_BITS'(i);
                r.hi_agent = pscc_pkg::AGENT_BITS'(j);
                r.conflict_step = 8'(t + 1); r.kind = 1'b1;
                {r.where_row, r.where_col} = pa; {r.other_row, r.other_col} = na;
              end
            end
          end
        end
        if (hit && r.conflict_count != pscc_pkg::COUNT_MAX) r.conflict_count++;
      end
    end
    r.makespan = 9'(span);
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // follow register writes and transfers
  always @(posedge clk) begin
    report_t exp_r;
    logic [3:0] ag;
    logic [7:0] st;
    if (rst) begin
      n_active <= 5'd2;
      for (int a = 0; a < pscc_pkg::MAX_AGENTS; a++) plen[a] = '0;
      fail_count = 0;
      reports_due = {};
    end else begin
      if (cfg_we) n_active <= cfg_wdata;
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          reports_due = {reports_due, predict_report()};
        end else begin
          ag = s_tdata[3:0];
          st = s_tdata[11:4];
          grid_pos[ag][st] = {s_tdata[19:12], s_tdata[27:20]};
          if (s_tlast) plen[ag] = pscc_pkg::LEN_BITS'(st) + pscc_pkg::LEN_BITS'(1);
        end
      end
      if (m_tvalid && m_tready) begin
        if (reports_due.size() == 0) begin
          $error("report transfer with none expected");
          fail_count++;
        end else begin
          exp_r = reports_due.pop_front();
          check_field("found", int'(exp_r.found), int'(m_tuser[0]));
          check_field("kind", int'(exp_r.kind), int'(m_tuser[1]));
          check_field("lo_agent", int'(exp_r.lo_agent), int'(m_tdata[3:0]));
          check_field("hi_agent", int'(exp_r.hi_agent), int'(m_tdata[7:4]));
          check_field("conflict_step", int'(exp_r.conflict_step), int'(m_tdata[15:8]));
          check_field("where_row", int'(exp_r.where_row), int'(m_tdata[23:16]));
          check_field("where_col", int'(exp_r.where_col), int'(m_tdata[31:24]));
          check_field("other_row", int'(exp_r.other_row), int'(m_tdata[39:32]));
          check_field("other_col", int'(exp_r.other_col), int'(m_tdata[47:40]));
          check_field("conflict_count", int'(exp_r.conflict_count), int'(m_tdata[54:48]));
          check_field("makespan", int'(exp_r.makespan), int'(m_tdata[63:55]));
          check_field("total_cost", int'(exp_r.total_cost), int'(m_tdata[76:64]));
        end
      end
    end
    pending = reports_due.size();
  end
endmodule
`default_nettype wire

@@ tb/path_set_conflict_checker_test.sv @@
// Top of the path-set conflict checker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module path_set_conflict_checker_test;
  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fail_count;
  int          pending;
  bit          calm;
  bit          hold_off;
  int          hold_cycles;
  int          sent_items;
  bit          written [pscc_pkg::MAX_AGENTS][pscc_pkg::MAX_STEPS];
  int          loaded_len [pscc_pkg::MAX_AGENTS];

  path_set_conflict_checker dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  path_set_conflict_monitor mon (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 0;
        for (int c = 0; c < hold_cycles; c++) @(posedge clk);
        hold_off = 0;
        m_tready <= 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // one transfer, with a random gap ahead of it
  task automatic send(bit is_run, int ag, int st, int row, int col, bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= is_run;
    s_tlast  <= last;
    s_tdata  <= {4'b0, col[7:0], row[7:0], st[7:0], ag[3:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
    if (!is_run) begin
      written[ag][st] = 1;
      if (last) loaded_len[ag] = st + 1;
    end
  endtask

  task automatic go_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_agents(int n);
    go_idle();
    cfg_we    <= 1;
    cfg_wdata <= 5'(n);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // full path of given length on a grid of side span+1, small spans make collisions
  task automatic load_path(int ag, int len, int span);
    int r, c;
    r = $urandom_range(0, span);
    c = $urandom_range(0, span);
    for (int t = 0; t < len; t++) begin
      if ($urandom_range(0, 1)) r = (r + $urandom_range(0, 2) + span) % (span + 1);
      else c = (c + $urandom_range(0, 2) + span) % (span + 1);
      send(0, ag, t, r, c, t == len - 1);
    end
  endtask

  initial begin
    int n, ag, st;
    rst = 1;
    cfg_we = 0; cfg_wdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
    calm = 0; hold_off = 0; hold_cycles = 0; sent_items = 0;
    for (int a = 0; a < pscc_pkg::MAX_AGENTS; a++) begin
      loaded_len[a] = 0;
      for (int t = 0; t < pscc_pkg::MAX_STEPS; t++) written[a][t] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: step 0 for every agent, vertex and edge swap, extremes
    for (int a = 0; a < pscc_pkg::MAX_AGENTS; a++) send(0, a, 0, 255 - a, a, 0);
    send(1, 0, 0, 0, 0, 0);                       // reset agent count, no marks
    send(0, 0, 0, 5, 5, 0); send(0, 0, 1, 5, 6, 1);
    send(0, 1, 0, 5, 6, 0); send(0, 1, 1, 5, 5, 1); // edge swap
    send(1, 0, 0, 0, 0, 0);
    send(0, 1, 1, 5, 6, 1);                        // vertex at final step
    send(0, 1, 1, 5, 6, 1);                        // repeated mark
    send(1, 0, 0, 0, 0, 0);
    set_agents(0);
    send(1, 0, 0, 0, 0, 0);
    set_agents(31);
    send(1, 0, 0, 0, 0, 0);
    // longest path, every step written, corners of the grid at both ends
    for (int t = 0; t < pscc_pkg::MAX_STEPS; t++)
      send(0, 15, t, t, 255 - t, t == pscc_pkg::MAX_STEPS - 1);
    set_agents(16);
    send(1, 0, 0, 0, 0, 0);

    // back pressure: receiver holds off while runs pile up
    hold_cycles = 3000;
    hold_off = 1;
    set_agents(2);
    for (int k = 0; k < 4; k++) send(1, 0, 0, 0, 0, 0);
    go_idle();

    // random: mostly whole path sets then a run
    while (sent_items < 1800) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 16) : $urandom_range(1, 6);
      if (sent_items > 1500) calm = 1;
      set_agents(n);
      for (int a = 0; a < n; a++) begin
        if ($urandom_range(0, 3) != 0 || loaded_len[a] == 0) begin
          st = $urandom_range(1, 8);
          load_path(a, st, $urandom_range(1, 3) == 1 ? 255 : 3);
        end
      end
      // noise: overwrite a written position, sometimes re-mark
      for (int k = 0; k < $urandom_range(0, 3); k++) begin
        ag = $urandom_range(0, 15);
        st = $urandom_range(0, 255);
        if (written[ag][st] && (st < loaded_len[ag] || loaded_len[ag] == 0)) begin
          send(0, ag, st, $urandom_range(0, 3), $urandom_range(0, 3),
               st > 0 && $urandom_range(0, 3) == 0);
        end
      end
      send(1, 0, 0, 0, 0, 0);
    end
    go_idle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
